FILE: hw/rtl/positional_list_store_defines.svh
// Assertion helpers shared by the list store modules.
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that forces a condition in the next one.
`define PLS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: hw/rtl/pls_pkg.sv
package pls_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 5;
  localparam int unsigned LenW  = 5;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SHIFT,
    S_PUT,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic eval;
    logic wr_tail;
    logic wr_put;
    logic rd_pos;
    logic rd_start;
    logic shift_step;
    logic cnt_inc;
    logic cnt_dec;
    logic res_load;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_e  op;
    logic err;
    logic at_end;
    logic shift_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/pls_intf.sv
interface pls_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         command;
  logic [pls_pkg::PosW-1:0]           position;
  logic signed [pls_pkg::DataW-1:0]   value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

interface pls_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [pls_pkg::DataW-1:0]   read_value;
  logic [pls_pkg::LenW-1:0]           length;
  logic [1:0]                         status;

  modport source (output valid, read_value, length, status, input ready);
  modport sink   (input valid, read_value, length, status, output ready);
endinterface

FILE: hw/rtl/pls_dp.sv
`include "positional_list_store_defines.svh"

module pls_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pls_pkg::dp_cmd_t                  cmd_i,
  output pls_pkg::dp_stat_t                 stat_o,
  input  logic [1:0]                        command_i,
  input  logic [pls_pkg::PosW-1:0]          position_i,
  input  logic signed [pls_pkg::DataW-1:0]  value_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic signed [pls_pkg::DataW-1:0]  read_value_o,
  output logic [pls_pkg::LenW-1:0]          length_o,
  output logic [1:0]                        status_o
);
  import pls_pkg::*;

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned ExtW  = ((CntW > PosW) ? CntW : PosW) + 1;

  logic signed [DataW-1:0] mem [CAPACITY];

  op_e                     op_q;
  logic [PosW-1:0]         pos_q;
  logic signed [DataW-1:0] val_q;
  logic [CntW-1:0]         count_q;
  logic [AddrW-1:0]        ptr_q;
  logic signed [DataW-1:0] rdata_q;
  status_e                 st_q;
  status_e                 st_d;

  logic                    res_valid_q;
  logic signed [DataW-1:0] res_value_q;
  logic [LenW-1:0]         res_len_q;
  status_e                 res_status_q;

  logic [ExtW-1:0]  pos_ext;
  logic [ExtW-1:0]  cnt_ext;
  logic             full;
  logic             empty;
  logic             is_ins;
  logic [AddrW-1:0] pos_idx;
  logic [AddrW-1:0] cnt_idx;
  logic [AddrW-1:0] cnt_m1;
  logic             shift_last;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic signed [DataW-1:0] wr_data;
  logic             rd_en;
  logic             rd_adv;
  logic [AddrW-1:0] rd_addr;

  assign pos_ext = ExtW'(pos_q);
  assign cnt_ext = ExtW'(count_q);
  assign full    = (cnt_ext == ExtW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign is_ins  = (op_q == OP_INSERT);
  assign pos_idx = AddrW'(pos_ext - ExtW'(1));
  assign cnt_idx = count_q[AddrW-1:0];
  assign cnt_m1  = AddrW'(cnt_ext - ExtW'(1));

  // Status of the held command against the current length.
  always_comb begin
    st_d = ST_OK;
    unique case (op_q)
      OP_APPEND: begin
        if (full) st_d = ST_FULL;
      end
      OP_INSERT: begin
        if (full) begin
          st_d = ST_FULL;
        end else if (pos_q == '0 || pos_ext > cnt_ext + ExtW'(1)) begin
          st_d = ST_RANGE;
        end
      end
      OP_DELETE, OP_READ: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else if (pos_q == '0 || pos_ext > cnt_ext) begin
          st_d = ST_RANGE;
        end
      end
    endcase
  end

  // Insert walks down to the new slot, delete walks up to the last entry.
  assign shift_last = is_ins ? (ptr_q == pos_idx) : (ptr_q == cnt_m1);

  assign stat_o.op         = op_q;
  assign stat_o.err        = (st_d != ST_OK);
  assign stat_o.at_end     = is_ins ? (pos_ext == cnt_ext + ExtW'(1)) : (pos_ext == cnt_ext);
  assign stat_o.shift_last = shift_last;
  assign stat_o.out_free   = !res_valid_q || res_ready_i;

  // Single write port.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt_idx;
    wr_data = val_q;
    priority if (cmd_i.wr_tail) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr_put) begin
      wr_en   = 1'b1;
      wr_addr = pos_idx;
    end else if (cmd_i.shift_step) begin
      wr_en   = 1'b1;
      wr_addr = is_ins ? ptr_q + AddrW'(1) : ptr_q - AddrW'(1);
      wr_data = rdata_q;
    end else begin
      wr_en = 1'b0;
    end
  end

  // Single read port; the shift reads one entry ahead of the write.
  assign rd_adv = cmd_i.shift_step && !shift_last;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos_idx;
    priority if (cmd_i.rd_pos) begin
      rd_en = 1'b1;
    end else if (cmd_i.rd_start) begin
      rd_en   = 1'b1;
      rd_addr = is_ins ? cnt_m1 : AddrW'(pos_ext);
    end else if (rd_adv) begin
      rd_en   = 1'b1;
      rd_addr = is_ins ? ptr_q - AddrW'(1) : ptr_q + AddrW'(1);
    end else begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(command_i);
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.eval) begin
      st_q <= st_d;
    end
    if (cmd_i.rd_start || rd_adv) begin
      ptr_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      count_q <= count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_value_q  <= (op_q == OP_READ && st_q == ST_OK) ? rdata_q : '0;
      res_len_q    <= cnt_ext[LenW-1:0];
      res_status_q <= st_q;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign read_value_o = res_value_q;
  assign length_o     = res_len_q;
  assign status_o     = res_status_q;

  `PLS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(CAPACITY), "count above capacity")
  `PLS_ASSERT(a_inc_not_full, clk_i, rst_ni, !(cmd_i.cnt_inc && full), "growth of a full list")
  `PLS_ASSERT(a_no_overwrite, clk_i, rst_ni, !(cmd_i.res_load && res_valid_q && !res_ready_i), "pending result overwritten")
  `PLS_ASSERT(a_port_clash, clk_i, rst_ni, !(wr_en && rd_en && wr_addr == rd_addr), "read and write hit one entry")

endmodule

FILE: hw/rtl/pls_ctrl.sv
`include "positional_list_store_defines.svh"

module pls_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pls_pkg::dp_stat_t  stat_i,
  output pls_pkg::dp_cmd_t   cmd_o
);
  import pls_pkg::*;

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.err) begin
          state_d = S_DONE;
        end else if ((stat_i.op == OP_INSERT || stat_i.op == OP_DELETE) && !stat_i.at_end) begin
          state_d = S_SHIFT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_last) state_d = (stat_i.op == OP_INSERT) ? S_PUT : S_DONE;
      end
      S_PUT: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        if (!stat_i.err) begin
          unique case (stat_i.op)
            OP_APPEND: begin
              cmd_o.wr_tail = 1'b1;
              cmd_o.cnt_inc = 1'b1;
            end
            OP_READ: begin
              cmd_o.rd_pos = 1'b1;
            end
            OP_INSERT: begin
              if (stat_i.at_end) begin
                cmd_o.wr_put  = 1'b1;
                cmd_o.cnt_inc = 1'b1;
              end else begin
                cmd_o.rd_start = 1'b1;
              end
            end
            OP_DELETE: begin
              if (stat_i.at_end) begin
                cmd_o.cnt_dec = 1'b1;
              end else begin
                cmd_o.rd_start = 1'b1;
              end
            end
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        cmd_o.cnt_dec    = stat_i.shift_last && (stat_i.op == OP_DELETE);
      end
      S_PUT: begin
        cmd_o.wr_put  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
      end
      S_DONE: begin
        cmd_o.res_load = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  `PLS_ASSERT_NEXT(a_accept_eval, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_EVAL, "accept did not start evaluation")
  `PLS_ASSERT_NEXT(a_err_done, clk_i, rst_ni, state_q == S_EVAL && stat_i.err, state_q == S_DONE, "failed command touched the store")
  `PLS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, state_q == S_DONE && stat_i.out_free, state_q == S_IDLE, "result hand-off stalled")

endmodule

FILE: hw/rtl/positional_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit entries with positional edits.
// Commands arrive as items on cmd_i (command, position, value); every command
// returns exactly one item on res_o (read_value, length, status). Positions
// are 1-based. Append adds at the end, insert places a value at 1..length+1,
// delete removes the entry at 1..length and closes the gap, read returns it.
// A failed command leaves the list untouched and reports empty, out of range
// or full in status; read_value is zero for anything but a successful read.
// One command is handled at a time. An accepted command is evaluated; insert and
// delete further move the entries behind the position one per cycle through
// the single read and write port of the entry memory, insert then writes the
// new value, and every command ends by loading its result into the output
// register. Append, read, failed commands and edits at the tail move nothing.
// The result sits in an output register; while res_o is stalled the block
// holds the next result in its final state and accepts no new command.
// Reset empties the list (length zero) and drops any pending result; the
// entry memory itself is not cleared, since only held entries are ever read.
module positional_list_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  pls_cmd_if.sink          cmd_i,
  pls_res_if.source        res_o
);
  import pls_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;

  // Sequencer: walks each command through evaluate, shift, put and hand-off.
  pls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  assign cmd_i.ready = in_ready;

  // Entry memory, length counter, range checks and the output register.
  pls_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .command_i    (cmd_i.command),
    .position_i   (cmd_i.position),
    .value_i      (cmd_i.value),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .read_value_o (res_o.read_value),
    .length_o     (res_o.length),
    .status_o     (res_o.status)
  );

endmodule
